[design/linear_interp_resampler_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler checks.
// The clock and reset of the asserting module are taken as clk and rst.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

// Property checked outside of reset.
`define LIR_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("resampler check failed");

// Property that must also hold across reset.
`define LIR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("resampler reset check failed");

`endif

[design/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the linear interpolation resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  // Output counter width and per-sample burst cap.
  localparam int COUNT_BITS = 24;
  localparam int MAX_BURST  = 64;
  localparam int BURST_BITS = $clog2(MAX_BURST + 1);
  localparam int LEN_BITS   = 24;
  localparam int CMP_BITS   = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_FORMAT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_LENGTH = 2'd2;

  // Configuration reset values.
  localparam logic [16:0]         PHASE_STEP_RESET    = 17'd65536;
  localparam logic                SAMPLE_FORMAT_RESET = 1'b0;
  localparam logic [LEN_BITS-1:0] OUTPUT_LENGTH_RESET = '0;

  // Sample format codes.
  localparam logic FMT_U8  = 1'b0;
  localparam logic FMT_S16 = 1'b1;

  // Bias that makes the scaled sum non-negative before the constant divide.
  // 8-bit:  q = floor((N + 127) / 255) - 32768.
  // 16-bit: q = floor((M + 32769 * 65535) / 65535) - 32768.
  localparam logic signed [33:0] BIAS_U8  = 34'sd127;
  localparam logic signed [33:0] BIAS_S16 = 34'sd2147516415;
  localparam logic [16:0] DIV_S16 = 17'd65535;
  localparam logic [8:0]  DIV_U8  = 9'd255;

  // Command from the controller to the datapath: one output to compute.
  typedef struct packed {
    logic        valid;
    logic        fmt;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] frac;
    logic        last;
  } lir_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic advance;
  } lir_status_t;

endpackage

`default_nettype wire

[design/linear_interp_resampler_top.sv]
// A sample that opens a pair reaches the output through the PAIR state, the command
// register and the s1, s2 and output registers of the datapath. The controller takes
// a sample only in IDLE and issues outputs in PAIR or FILL as the datapath advances;
// a pair cut by the burst cap or the output count, and a fill, close on an empty step.
// Beats leave one per cycle unless m_tready is low, which stalls the 3-stage pipeline.
// Reset (rst, synchronous): clears stream state and loads the register reset values.
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Linear interpolation sample rate converter with Q1.15 output, holding the
// configuration registers and joining the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [15:0]                         s_tdata,   // [15:0] sample_in
  input  wire logic                                s_tlast,   // last_sample
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [15:0]                              m_tdata,   // [15:0] sample_out
  output logic                                     m_tlast,   // last_out
  input  wire logic                                cfg_we,
  input  wire logic [lir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [23:0]                         cfg_wdata
);

  logic [16:0]                      phase_step;
  logic                             sample_format;
  logic [lir_pkg::LEN_BITS-1:0]     output_length;
  lir_pkg::lir_cmd_t                cmd;
  lir_pkg::lir_status_t             status;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= lir_pkg::PHASE_STEP_RESET;
      sample_format <= lir_pkg::SAMPLE_FORMAT_RESET;
      output_length <= lir_pkg::OUTPUT_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lir_pkg::CFG_PHASE_STEP:    phase_step    <= cfg_wdata[16:0];
        lir_pkg::CFG_SAMPLE_FORMAT: sample_format <= cfg_wdata[0];
        lir_pkg::CFG_OUTPUT_LENGTH: output_length <= cfg_wdata[lir_pkg::LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencing of pairs and fill outputs.
  lir_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_sample     (s_tdata),
    .in_last       (s_tlast),
    .phase_step    (phase_step),
    .sample_format (sample_format),
    .output_length (output_length),
    .status        (status),
    .cmd           (cmd)
  );

  // Interpolation, scaling and output register.
  lir_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

`default_nettype wire

[design/lir_ctrl.sv]
// ----------------------------------------------------------------------------
// lir_ctrl
// Controller: accepts source samples, walks the phase across each sample pair,
// fills the tail of the sound and issues one conversion command per output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [15:0]                      in_sample,
  input  wire logic                             in_last,
  input  wire logic [16:0]                      phase_step,
  input  wire logic                             sample_format,
  input  wire logic [lir_pkg::LEN_BITS-1:0]     output_length,
  input  wire lir_pkg::lir_status_t             status,
  output lir_pkg::lir_cmd_t                     cmd
);

  typedef enum logic [1:0] {
    IDLE,
    PAIR,
    FILL
  } state_t;

  state_t state;

  logic [15:0]                          cur_sample;
  logic                                 cur_last;
  logic [15:0]                          prev_sample;
  logic                                 have_prev;
  logic [15:0]                          phase_frac;
  logic [1:0]                           skip_count;
  logic [lir_pkg::COUNT_BITS-1:0]       emitted;
  logic [lir_pkg::BURST_BITS-1:0]       burst;

  logic [lir_pkg::COUNT_BITS-1:0]       emitted_inc;
  logic [lir_pkg::BURST_BITS-1:0]       burst_inc;
  logic                                 room_now;
  logic                                 room_after;
  logic [17:0]                          phase_sum;
  logic                                 advance_pair;
  logic                                 pair_final;
  logic                                 issue;

  assign in_ready = (state == IDLE);

  // An output is issued in this cycle when there is room for it.
  assign issue = ((state == PAIR) || (state == FILL)) && room_now;

  // Room checks for this output and for the one after it.
  always_comb begin
    emitted_inc = emitted + lir_pkg::COUNT_BITS'(1);
    burst_inc   = burst + lir_pkg::BURST_BITS'(1);
    room_now    = (burst < lir_pkg::BURST_BITS'(lir_pkg::MAX_BURST)) &&
                  (lir_pkg::CMP_BITS'(emitted) < lir_pkg::CMP_BITS'(output_length));
    room_after  = (burst_inc < lir_pkg::BURST_BITS'(lir_pkg::MAX_BURST)) &&
                  (lir_pkg::CMP_BITS'(emitted_inc) < lir_pkg::CMP_BITS'(output_length));
  end

  // Phase step and the last-beat decision for an interpolated output.
  // Only a last sample marks a beat, and only when no fill beat follows.
  always_comb begin
    phase_sum    = {2'b00, phase_frac} + {1'b0, phase_step};
    advance_pair = |phase_sum[17:16];
    pair_final   = cur_last && !room_after;
  end

  // State, stream state and the registered command.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      prev_sample <= '0;
      have_prev   <= 1'b0;
      phase_frac  <= '0;
      skip_count  <= '0;
      emitted     <= '0;
      burst       <= '0;
      cmd.valid   <= 1'b0;
    end else begin
      if (status.advance) begin
        cmd.valid <= issue;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            cur_sample <= in_sample;
            cur_last   <= in_last;
            burst      <= '0;
            if (have_prev && (skip_count == 2'd0)) begin
              state <= PAIR;
            end else begin
              if (have_prev) begin
                skip_count <= skip_count - 2'd1;
              end
              prev_sample <= in_sample;
              have_prev   <= 1'b1;
              state       <= in_last ? FILL : IDLE;
            end
          end
        end
        PAIR: begin
          if (!room_now) begin
            prev_sample <= cur_sample;
            state       <= cur_last ? FILL : IDLE;
          end else if (status.advance) begin
            cmd.fmt    <= sample_format;
            cmd.a      <= prev_sample;
            cmd.b      <= cur_sample;
            cmd.frac   <= phase_frac;
            cmd.last   <= pair_final;
            burst      <= burst_inc;
            emitted    <= emitted_inc;
            phase_frac <= phase_sum[15:0];
            if (advance_pair) begin
              skip_count  <= phase_sum[17:16] - 2'd1;
              prev_sample <= cur_sample;
              state       <= cur_last ? FILL : IDLE;
            end
          end
        end
        FILL: begin
          if (!room_now) begin
            // End of sound: the stream state returns to its reset value.
            prev_sample <= '0;
            have_prev   <= 1'b0;
            phase_frac  <= '0;
            skip_count  <= '0;
            emitted     <= '0;
            state       <= IDLE;
          end else if (status.advance) begin
            cmd.fmt   <= sample_format;
            cmd.a     <= prev_sample;
            cmd.b     <= prev_sample;
            cmd.frac  <= '0;
            cmd.last  <= !room_after;
            burst     <= burst_inc;
            emitted   <= emitted_inc;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/lir_datapath.sv]
// ----------------------------------------------------------------------------
// lir_datapath
// Three-stage conversion pipeline: interpolation multiply, biased sum with a
// first digit fold, then the constant divide finish, saturation and the
// output register. The whole pipeline stalls while an output beat waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lir_pkg::lir_cmd_t    cmd,
  output lir_pkg::lir_status_t      status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               out_sample,
  output logic                      out_last
);

  logic                advance;

  // Stage 0 operands.
  logic signed [16:0]  a_ext;
  logic signed [16:0]  b_ext;
  logic signed [17:0]  diff;
  logic signed [34:0]  prod_full;

  // Stage 1 registers.
  logic                s1_valid;
  logic                s1_fmt;
  logic                s1_last;
  logic signed [16:0]  s1_a;
  logic signed [33:0]  s1_prod;

  // Stage 1 to 2 logic.
  logic signed [33:0]  acc;
  logic signed [33:0]  biased;
  logic [16:0]         q0;
  logic [17:0]         r0;

  // Stage 2 registers.
  logic                s2_valid;
  logic                s2_fmt;
  logic                s2_last;
  logic [16:0]         s2_q0;
  logic [17:0]         s2_r0;

  // Stage 2 to output logic.
  logic [9:0]          q1;
  logic [10:0]         r1_u8;
  logic [16:0]         r1_s16;
  logic [2:0]          q2;
  logic [8:0]          r2;
  logic                corr;
  logic [17:0]         quot;
  logic [15:0]         result;

  assign advance        = !out_valid || out_ready;
  assign status.advance = advance;

  // Operands in the selected format; the pair is a + (b - a) * f / 65536.
  always_comb begin
    if (cmd.fmt == lir_pkg::FMT_S16) begin
      a_ext = {cmd.a[15], cmd.a};
      b_ext = {cmd.b[15], cmd.b};
    end else begin
      a_ext = {9'b0, cmd.a[7:0]};
      b_ext = {9'b0, cmd.b[7:0]};
    end
    diff      = {b_ext[16], b_ext} - {a_ext[16], a_ext};
    prod_full = diff * $signed({1'b0, cmd.frac});
  end

  // Weighted sum, bias, and the first fold of the constant divide.
  always_comb begin
    acc    = $signed({s1_a[16], s1_a, 16'h0000}) + s1_prod;
    biased = acc + ((s1_fmt == lir_pkg::FMT_S16) ? lir_pkg::BIAS_S16 : lir_pkg::BIAS_U8);
    if (s1_fmt == lir_pkg::FMT_S16) begin
      q0 = biased[32:16];
      r0 = {2'b00, biased[15:0]} + {1'b0, q0};
    end else begin
      q0 = biased[24:8];
      r0 = {10'b0, biased[7:0]} + {1'b0, q0};
    end
  end

  // Remaining folds, final correction and saturation to Q1.15.
  always_comb begin
    r1_u8  = '0;
    r1_s16 = '0;
    q2     = '0;
    r2     = '0;
    if (s2_fmt == lir_pkg::FMT_S16) begin
      q1     = {8'b0, s2_r0[17:16]};
      r1_s16 = {1'b0, s2_r0[15:0]} + {15'b0, s2_r0[17:16]};
      corr   = (r1_s16 >= lir_pkg::DIV_S16);
    end else begin
      q1    = s2_r0[17:8];
      r1_u8 = {3'b000, s2_r0[7:0]} + {1'b0, q1};
      q2    = r1_u8[10:8];
      r2    = {1'b0, r1_u8[7:0]} + {6'b0, q2};
      corr  = (r2 >= lir_pkg::DIV_U8);
    end
    quot = {1'b0, s2_q0} + {8'b0, q1} + {15'b0, q2} + {17'b0, corr};
    if (quot[17:16] != 2'b00) begin
      result = 16'h7fff;
    end else begin
      result = quot[15:0] ^ 16'h8000;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_fmt     <= cmd.fmt;
      s1_last    <= cmd.last;
      s1_a       <= a_ext;
      s1_prod    <= prod_full[33:0];
      s2_fmt     <= s1_fmt;
      s2_last    <= s1_last;
      s2_q0      <= q0;
      s2_r0      <= r0;
      out_sample <= result;
      out_last   <= s2_last;
    end
  end

endmodule

`default_nettype wire

[design/lir_checker.sv]
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks of the resampler: reset state, minimum latency out of
// reset and output beat stability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_interp_resampler_top_assert.svh"

module lir_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  // Right after reset the block is empty and ready for a sample.
  `LIR_ASSERT_ALWAYS(a_reset_state, $past(rst) |-> (s_tready && !m_tvalid))

  // A beat can only rise after reset has stayed clear while it passed the controller and pipeline.
  `LIR_ASSERT(a_min_latency, $rose(m_tvalid) |-> (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)))

  // A waiting beat stays offered.
  `LIR_ASSERT(a_valid_hold, (m_tvalid && !m_tready) |=> m_tvalid)

  // A waiting beat keeps its payload.
  `LIR_ASSERT(a_data_hold, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))

endmodule

bind linear_interp_resampler_top lir_checker u_lir_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/sv/lir_stream_checker.sv]
// ----------------------------------------------------------------------------
// lir_stream_checker
// Watches the sample, result and register ports of the resampler. Each
// accepted sample runs through an interpolation predictor. The predicted Q1.15
// beats are queued, and every result beat is compared with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_stream_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  input  wire logic                               s_tready,
  input  wire logic [15:0]                        s_tdata,   // [15:0] sample_in
  input  wire logic                               s_tlast,   // last_sample
  input  wire logic                               m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic [15:0]                        m_tdata,   // [15:0] sample_out
  input  wire logic                               m_tlast,   // last_out
  input  wire logic                               cfg_we,
  input  wire logic [lir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [23:0]                        cfg_wdata,
  output int                                      pending,
  output int                                      fail_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } q15_beat_t;

  // Shadow copy of the configuration registers.
  logic [16:0]                    cur_step;
  logic                           cur_format;
  logic [lir_pkg::LEN_BITS-1:0]   cur_length;

  // Shadow copy of the stream state.
  logic [15:0]                    held_sample;
  logic                           held_valid;
  int unsigned                    frac_phase;
  logic [1:0]                     skip_pairs;
  logic [lir_pkg::COUNT_BITS-1:0] emitted;

  q15_beat_t expected_beats[$];
  q15_beat_t staged_beat;
  bit        staged_valid;
  int        mismatches = 0;
  int        beat_no = 0;

  assign fail_count = mismatches;

  // Divide rounding to nearest, halves toward plus infinity (den > 0).
  function automatic longint round_half_up(longint num, longint den);
    longint n;
    longint d;
    longint q;
    n = 2 * num + den;
    d = 2 * den;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Interpolated value of the pair (a, b) at fraction frac, saturated Q1.15.
  function automatic logic signed [15:0] to_q15(logic [15:0] a, logic [15:0] b,
                                                logic [15:0] frac);
    longint wa;
    longint wb;
    longint q;
    wa = 65536 - longint'(frac);
    wb = longint'(frac);
    if (cur_format == lir_pkg::FMT_S16) begin
      q = round_half_up(longint'($signed(a)) * wa + longint'($signed(b)) * wb + 32768,
                        65535);
    end else begin
      q = round_half_up(2 * (longint'(a[7:0]) * wa + longint'(b[7:0]) * wb) - 16711680,
                        510);
    end
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic bit has_room(int n);
    return (n < lir_pkg::MAX_BURST) && (emitted < cur_length);
  endfunction

  function automatic void clear_stream();
    held_sample = '0;
    held_valid  = 1'b0;
    frac_phase  = 0;
    skip_pairs  = '0;
    emitted     = '0;
  endfunction

  // The newest beat of a step is held back so that its last flag can be set.
  task automatic emit_sample(logic signed [15:0] value);
    if (staged_valid) expected_beats.push_back(staged_beat);
    staged_beat  = '{sample: value, last: 1'b0};
    staged_valid = 1'b1;
    emitted      = emitted + 1'b1;
  endtask

  // Works out the beats that one accepted sample causes.
  task automatic predict_step(logic [15:0] x, logic last_in);
    int          n;
    int unsigned adv;
    bit          pair_done;
    n            = 0;
    pair_done    = 1'b0;
    staged_valid = 1'b0;
    if (held_valid) begin
      if (skip_pairs != 2'd0) begin
        skip_pairs = skip_pairs - 2'd1;
      end else begin
        while (!pair_done && has_room(n)) begin
          emit_sample(to_q15(held_sample, x, frac_phase[15:0]));
          n++;
          frac_phase = frac_phase + cur_step;
          adv        = frac_phase >> 16;
          frac_phase = frac_phase & 32'hffff;
          if (adv != 0) begin
            skip_pairs = 2'(adv - 1);
            pair_done  = 1'b1;
          end
        end
      end
    end
    held_sample = x;
    held_valid  = 1'b1;

    // The final sample of a sound pads the output count with itself.
    if (last_in) begin
      while (has_room(n)) begin
        emit_sample(to_q15(x, x, 16'd0));
        n++;
      end
    end
    if (staged_valid) begin
      staged_beat.last = last_in;
      expected_beats.push_back(staged_beat);
    end
    if (last_in) clear_stream();
  endtask

  task automatic report(string msg);
    if (mismatches < REPORT_LIMIT) $display("checker: %s", msg);
    mismatches++;
  endtask

  // Compares one result beat with the oldest expected beat.
  task automatic check_beat();
    q15_beat_t want;
    beat_no++;
    if (expected_beats.size() == 0) begin
      report($sformatf("beat %0d arrived with nothing expected, sample_out %0d last_out %0b",
                       beat_no, $signed(m_tdata), m_tlast));
    end else begin
      want = expected_beats.pop_front();
      if (m_tdata !== want.sample)
        report($sformatf("beat %0d sample_out expected %0d got %0d",
                         beat_no, want.sample, $signed(m_tdata)));
      if (m_tlast !== want.last)
        report($sformatf("beat %0d last_out expected %0b got %0b",
                         beat_no, want.last, m_tlast));
    end
  endtask

  // Register writes, then accepted samples, then result beats.
  always @(posedge clk) begin
    if (rst) begin
      cur_step   = lir_pkg::PHASE_STEP_RESET;
      cur_format = lir_pkg::SAMPLE_FORMAT_RESET;
      cur_length = lir_pkg::OUTPUT_LENGTH_RESET;
      clear_stream();
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lir_pkg::CFG_PHASE_STEP:    cur_step   = cfg_wdata[16:0];
          lir_pkg::CFG_SAMPLE_FORMAT: cur_format = cfg_wdata[0];
          lir_pkg::CFG_OUTPUT_LENGTH: cur_length = cfg_wdata[lir_pkg::LEN_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_step(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_beat();
    end
    pending <= expected_beats.size();
  end

endmodule

[tb/sv/tb_linear_interp_resampler_top.sv]
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler_top
// Drives PCM samples and register settings into the resampler under random
// idling and one long result stall, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_interp_resampler_top;

  localparam logic [lir_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam logic [lir_pkg::LEN_BITS-1:0]       FULL_LENGTH = '1;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [15:0]                        s_tdata = '0;
  logic                               s_tlast = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [15:0]                        m_tdata;
  logic                               m_tlast;
  logic                               cfg_we = 1'b0;
  logic [lir_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [23:0]                        cfg_wdata = '0;

  int pending;
  int fail_count;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  linear_interp_resampler_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lir_stream_checker stream_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linear_interp_resampler_top verification failed");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off once it is asked for.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Writes all registers back to back, plus one write to the unused index.
  task automatic load_settings(logic [16:0] step, logic fmt,
                               logic [lir_pkg::LEN_BITS-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= lir_pkg::CFG_PHASE_STEP;
    cfg_wdata <= 24'(step);
    @(posedge clk);
    cfg_index <= lir_pkg::CFG_SAMPLE_FORMAT;
    cfg_wdata <= 24'(fmt);
    @(posedge clk);
    cfg_index <= lir_pkg::CFG_OUTPUT_LENGTH;
    cfg_wdata <= 24'(len);
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= 24'($urandom());
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offers one sample beat after a random gap and waits until it is taken.
  // Valid stays high on return so back-to-back beats need no second write.
  task automatic send_sample(logic [15:0] value, logic last_in);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last_in;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Lets the block run dry: every expected beat in, then a margin for
  // samples that cause no beat.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(5))
        0: return 16'h0000;
        1: return 16'h00FF;
        2: return 16'h7FFF;
        3: return 16'h8000;
        4: return 16'hFFFF;
        default: return 16'h0080;
      endcase
    end
    return 16'($urandom());
  endfunction

  // Sounds of random length with random content; the phase may end mid-sound.
  task automatic run_sounds(int count, int hold_at);
    int left_in_sound;
    int i;
    left_in_sound = $urandom_range(1, 16);
    for (i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      left_in_sound--;
      send_sample(pick_sample(), left_in_sound == 0);
      if (left_in_sound == 0) left_in_sound = $urandom_range(1, 16);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 21;
    rx_idle_pct = 51;

    // A zero output length gives no beats at all, not even a last one.
    load_settings(17'd65536, lir_pkg::FMT_U8, '0);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h8000, 1'b1);
    drain();

    // 8-bit extremes, upper byte ignored; the final sample fills to the cap.
    load_settings(17'd65536, lir_pkg::FMT_U8, FULL_LENGTH);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'hFF00, 1'b0);
    send_sample(16'h0080, 1'b0);
    send_sample(16'h00FF, 1'b1);
    drain();

    // 16-bit extremes at the largest step, so pairs get skipped.
    load_settings(17'h1FFFF, lir_pkg::FMT_S16, FULL_LENGTH);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    drain();

    // Output count runs out in mid-sound, then the format changes mid-sound.
    load_settings(17'd1024, lir_pkg::FMT_S16, 24'd10);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h1234, 1'b0);
    send_sample(16'hEDCB, 1'b0);
    drain();
    load_settings(17'd1024, lir_pkg::FMT_U8, 24'd20);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h0000, 1'b1);
    drain();

    // A zero step never leaves the pair, so every burst is cut at the cap;
    // then a sound of one sample.
    load_settings(17'd0, lir_pkg::FMT_S16, FULL_LENGTH);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h4000, 1'b1);
    drain();

    // Random part, sender idling less than the receiver.
    load_settings(17'd65536, lir_pkg::FMT_U8, FULL_LENGTH);
    run_sounds(80, 20);
    load_settings(17'($urandom_range(1024, 131071)), lir_pkg::FMT_S16,
                  24'($urandom_range(0, 3000)));
    run_sounds(80, -1);
    load_settings(17'h1FFFF, lir_pkg::FMT_S16, FULL_LENGTH);
    run_sounds(60, -1);

    // Receiver idling less than the sender.
    tx_idle_pct = 51;
    rx_idle_pct = 21;
    load_settings(17'd1024, lir_pkg::FMT_U8, 24'd5000);
    run_sounds(20, -1);
    load_settings(17'($urandom_range(1024, 131071)), 1'($urandom()),
                  24'($urandom_range(0, 40)));
    run_sounds(80, -1);
    load_settings(17'd700, lir_pkg::FMT_S16, FULL_LENGTH);
    run_sounds(15, -1);

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_settings(17'($urandom()), 1'($urandom()), 24'($urandom()));
    run_sounds(80, -1);
    load_settings(17'd16384, lir_pkg::FMT_U8, FULL_LENGTH);
    run_sounds(80, -1);

    if (fail_count == 0 && pending == 0) begin
      $display("linear_interp_resampler_top verification clean");
    end else begin
      $display("linear_interp_resampler_top verification failed");
    end
    $finish;
  end

endmodule
